/* rtl/bedf_pkg.sv */
// shared types, constants and helper functions for the banded edit distance filter
`default_nettype none
package bedf_pkg;

  localparam int QUERY_LENGTH = 20;
  localparam int HALF_BAND    = (QUERY_LENGTH - 1) / 2;
  localparam int SYM_W        = 8;
  localparam int COST_W       = 5;
  localparam int ROW_W        = $clog2(QUERY_LENGTH + 1);
  localparam int BAND_W       = ROW_W + 1;
  localparam int QUERY_REGS   = 20;
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 64;
  localparam int LIMIT_RESET  = 8;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_QUERY_LOW  = 2'd0,
    REG_QUERY_MID  = 2'd1,
    REG_QUERY_HIGH = 2'd2,
    REG_DIST_LIMIT = 2'd3
  } cfg_reg_t;

  // token handed from cell to cell
  typedef struct packed {
    logic  valid;
    logic  upd;
    logic  last;
    sym_t  sym;
    row_t  row;
    cost_t diag;
    cost_t left;
  } tok_t;

  function automatic cost_t cost_min(input cost_t a, input cost_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic cost_t cost_inc(input cost_t a);
    return (a == COST_MAX) ? a : cost_t'(a + cost_t'(1));
  endfunction

endpackage
`default_nettype wire

/* rtl/bedf_head.sv */
// input stage: row counter and token launch into the cell chain
`default_nettype none
module bedf_head (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           in_tvalid,
  input  wire bedf_pkg::sym_t in_tdata,
  input  wire logic           in_tlast,
  output bedf_pkg::tok_t      tok_o
);
  import bedf_pkg::*;

  row_t row_r, row_nxt;
  tok_t tok_r, tok_nxt;
  logic upd;

  assign upd = (row_r < row_t'(QUERY_LENGTH));

  always_comb begin
    row_nxt = row_r;
    tok_nxt = tok_r;
    if (adv) begin
      tok_nxt.valid = in_tvalid;
      tok_nxt.upd   = upd;
      tok_nxt.last  = in_tlast;
      tok_nxt.sym   = in_tdata;
      tok_nxt.row   = row_t'(row_r + row_t'(1));
      tok_nxt.diag  = cost_t'(row_r);
      tok_nxt.left  = cost_t'(row_r);
      if (in_tvalid) begin
        if (in_tlast) begin
          row_nxt = '0;
        end else if (upd) begin
          row_nxt = row_t'(row_r + row_t'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      tok_r <= '0;
    end else begin
      row_r <= row_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_tvalid && in_tlast |=> row_r == '0)
    else $error("row counter not cleared after record end");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_tvalid && !in_tlast && upd |=> row_r == row_t'($past(row_r) + row_t'(1)))
    else $error("row counter did not step");

endmodule
`default_nettype wire

/* rtl/bedf_cell.sv */
// one column of the cost row with its band check and update
`default_nettype none
module bedf_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire bedf_pkg::row_t col_idx,
  input  wire bedf_pkg::sym_t query_sym,
  input  wire bedf_pkg::tok_t tok_i,
  output bedf_pkg::tok_t      tok_o
);
  import bedf_pkg::*;

  localparam logic [BAND_W-1:0] HALF_B = BAND_W'(HALF_BAND);

  cost_t value_r, value_nxt;
  tok_t  tok_r, tok_nxt;
  cost_t up, best, cand;
  logic  [BAND_W-1:0] col_ext, row_ext;
  logic  in_band, is_first, is_top, mismatch;

  assign up      = value_r;
  assign col_ext = BAND_W'(col_idx);
  assign row_ext = BAND_W'(tok_i.row);
  assign in_band = (col_ext + HALF_B >= row_ext) && (col_ext <= row_ext + HALF_B);
  assign is_top  = (col_ext == row_ext + HALF_B);
  assign is_first = (row_ext <= HALF_B + BAND_W'(1)) ? (col_idx == row_t'(1))
                                                     : (col_ext + HALF_B == row_ext);
  assign mismatch = (tok_i.sym != query_sym);

  always_comb begin
    priority if (is_first) begin
      best = cost_min(tok_i.diag, up);
    end else if (is_top) begin
      best = cost_min(tok_i.diag, tok_i.left);
    end else begin
      best = cost_min(cost_min(tok_i.diag, up), tok_i.left);
    end
    if (tok_i.upd && in_band) begin
      cand = mismatch ? cost_inc(best) : tok_i.diag;
    end else begin
      cand = value_r;
    end
  end

  always_comb begin
    value_nxt = value_r;
    tok_nxt   = tok_r;
    if (adv) begin
      tok_nxt.valid = tok_i.valid;
      tok_nxt.upd   = tok_i.upd;
      tok_nxt.last  = tok_i.last;
      tok_nxt.sym   = tok_i.sym;
      tok_nxt.row   = tok_i.row;
      tok_nxt.diag  = value_r;
      tok_nxt.left  = cand;
      if (tok_i.valid) begin
        value_nxt = tok_i.last ? cost_t'(col_idx) : cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= cost_t'(col_idx);
      tok_r   <= '0;
    end else begin
      value_r <= value_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  a_col_reload: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tok_i.valid && tok_i.last |=> value_r == cost_t'(col_idx))
    else $error("cell not reloaded after record end");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(value_r) && $stable(tok_r))
    else $error("cell moved while stalled");

endmodule
`default_nettype wire

/* rtl/bedf_out.sv */
// result register at the end of the chain and stall control
`default_nettype none
module bedf_out (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bedf_pkg::tok_t  tok_i,
  input  wire bedf_pkg::cost_t limit,
  input  wire logic            out_tready,
  output logic                 out_tvalid,
  output logic [7:0]           out_tdata,
  output logic                 adv
);
  import bedf_pkg::*;

  logic  valid_r, valid_nxt;
  cost_t dist_r, dist_nxt;
  logic  within_r, within_nxt;
  logic  result_in;

  assign result_in = tok_i.valid && tok_i.last;
  assign adv = !(result_in && valid_r && !out_tready);

  always_comb begin
    valid_nxt  = valid_r;
    dist_nxt   = dist_r;
    within_nxt = within_r;
    if (adv) begin
      if (result_in) begin
        valid_nxt  = 1'b1;
        dist_nxt   = tok_i.left;
        within_nxt = (tok_i.left <= limit);
      end else if (out_tready) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    dist_r   <= dist_nxt;
    within_r <= within_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, within_r, dist_r};

  a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    result_in && adv |=> valid_r && dist_r == $past(tok_i.left))
    else $error("result lost at output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> valid_r && result_in)
    else $error("chain stalled without a waiting result");

endmodule
`default_nettype wire

/* rtl/banded_edit_distance_filter_top.sv */
// top level: configuration registers, head stage, chain of column cells, result register
//
// channel  dir  handshake              payload
// in_      in   in_tvalid / in_tready  in_tdata[7:0] symbol, in_tlast record end
// out_     out  out_tvalid/out_tready  out_tdata[4:0] edit distance, [5] within limit
// cfg_     in   cfg_we                 cfg_addr register index, cfg_wdata value
//
// one symbol per cycle while the chain does not stall
// a record end passes the head register, one register per column cell and then the result register
// the chain stalls only when a record end reaches the last cell while a result waits
// synchronous reset loads each cell with its column index and clears the row counter
`default_nettype none
module banded_edit_distance_filter_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // symbol
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [7:0]                        out_tdata,  // edit_distance, within_limit
  input  wire logic                         cfg_we,
  input  wire logic [bedf_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [bedf_pkg::CFG_DW-1:0]  cfg_wdata
);
  import bedf_pkg::*;

  logic [63:0] q_low_r, q_mid_r;
  logic [31:0] q_high_r;
  cost_t       limit_r;
  logic        adv;
  tok_t        tok [QUERY_LENGTH+1];
  sym_t        qsym [QUERY_LENGTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_low_r  <= '0;
      q_mid_r  <= '0;
      q_high_r <= '0;
      limit_r  <= cost_t'(LIMIT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_QUERY_LOW:  q_low_r  <= cfg_wdata;
        REG_QUERY_MID:  q_mid_r  <= cfg_wdata;
        REG_QUERY_HIGH: q_high_r <= cfg_wdata[31:0];
        REG_DIST_LIMIT: limit_r  <= cfg_wdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < QUERY_LENGTH; k++) begin : g_qsym
    if (k < 8) begin : g_low
      assign qsym[k] = q_low_r[8*k +: 8];
    end else if (k < 16) begin : g_mid
      assign qsym[k] = q_mid_r[8*(k-8) +: 8];
    end else if (k < QUERY_REGS) begin : g_high
      assign qsym[k] = q_high_r[8*(k-16) +: 8];
    end else begin : g_zero
      assign qsym[k] = '0;
    end
  end

  assign in_tready = adv;

  bedf_head u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .tok_o     (tok[0])
  );

  for (genvar j = 1; j <= QUERY_LENGTH; j++) begin : g_cell
    bedf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .col_idx   (row_t'(j)),
      .query_sym (qsym[j-1]),
      .tok_i     (tok[j-1]),
      .tok_o     (tok[j])
    );
  end

  bedf_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_i      (tok[QUERY_LENGTH]),
    .limit      (limit_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .adv        (adv)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output free");

endmodule
`default_nettype wire
